// ===== hdl/sld_pkg.sv =====
// Shared constants and types for the sync/length deframer.
package sld_pkg;

	localparam int SYNC_LENGTH_DEF  = 8;
	localparam int LENGTH_BYTES_DEF = 8;
	localparam int QUEUE_DEPTH_DEF  = 4;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       first_of_frame;
		logic       last_of_frame;
	} sld_item_t;

endpackage

// ===== hdl/sld_front.sv =====
// Front end: sync hunt, length capture and payload byte classification.
module sld_front
	import sld_pkg::*;
#(
	parameter int SYNC_LENGTH  = SYNC_LENGTH_DEF,
	parameter int LENGTH_BYTES = LENGTH_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] rx_byte,
	output logic       emit,
	output sld_item_t  item
);

	localparam int SCW = (SYNC_LENGTH > 1) ? $clog2(SYNC_LENGTH) : 1;
	localparam int HCW = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
	localparam int LW  = 8 * LENGTH_BYTES;

	localparam logic [SCW-1:0] SYNC_LAST = SCW'(SYNC_LENGTH - 1);
	localparam logic [HCW-1:0] HDR_LAST  = HCW'(LENGTH_BYTES - 1);

	typedef enum logic [2:0] {
		PH_HUNT = 3'b001,
		PH_LEN  = 3'b010,
		PH_DATA = 3'b100
	} phase_t;

	phase_t         phase_q;
	logic [SCW-1:0] sync_cnt_q;
	logic [HCW-1:0] hdr_cnt_q;
	logic [LW-1:0]  len_acc_q;
	logic [LW-1:0]  remaining_q;
	logic           at_start_q;

	logic [LW-1:0] len_next;
	logic          rem_last;

	assign len_next = (len_acc_q << 8) | LW'(rx_byte);
	assign rem_last = (remaining_q >> 1) == '0;

	assign emit                = take && (phase_q == PH_DATA);
	assign item.payload_byte   = rx_byte;
	assign item.first_of_frame = at_start_q;
	assign item.last_of_frame  = rem_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			sync_cnt_q  <= '0;
			hdr_cnt_q   <= '0;
			len_acc_q   <= '0;
			remaining_q <= '0;
			at_start_q  <= 1'b0;
		end else if (take) begin
			case (phase_q)
				PH_LEN: begin
					len_acc_q <= len_next;
					hdr_cnt_q <= hdr_cnt_q + 1'b1;
					if (hdr_cnt_q == HDR_LAST) begin
						hdr_cnt_q <= '0;
						if (len_next == '0) begin
							phase_q    <= PH_HUNT;
							sync_cnt_q <= '0;
							len_acc_q  <= '0;
						end else begin
							phase_q     <= PH_DATA;
							remaining_q <= len_next;
							at_start_q  <= 1'b1;
						end
					end
				end
				PH_DATA: begin
					at_start_q <= 1'b0;
					if (remaining_q != '0)
						remaining_q <= remaining_q - 1'b1;
					if (rem_last) begin
						phase_q    <= PH_HUNT;
						sync_cnt_q <= '0;
						hdr_cnt_q  <= '0;
						len_acc_q  <= '0;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
					if (rx_byte == SYNC_BYTE) begin
						if (sync_cnt_q == SYNC_LAST) begin
							sync_cnt_q <= '0;
							hdr_cnt_q  <= '0;
							len_acc_q  <= '0;
							phase_q    <= PH_LEN;
						end else begin
							sync_cnt_q <= sync_cnt_q + 1'b1;
						end
					end else begin
						sync_cnt_q <= '0;
					end
				end
			endcase
		end
	end

endmodule

// ===== hdl/sld_queue.sv =====
// Result queue between the front end and the output side.
module sld_queue
	import sld_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  sld_item_t wr_item,
	input  logic      rd_en,
	output sld_item_t rd_item,
	output logic      full,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	sld_item_t     mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hdl/sync_length_deframer.sv =====
// Top level of the sync-word, length-prefixed byte stream deframer.
// Takes one byte per cycle whenever full is low. A run of SYNC_LENGTH 0xFF
// bytes marks sync, the next LENGTH_BYTES bytes give the big-endian payload
// length, and that many bytes are then passed out with first/last-of-frame
// marks; a zero length goes straight back to hunting. A payload byte is
// written into a QUEUE_DEPTH-entry queue and is seen on the result side once
// it reaches the head of that queue; full rises only when that queue has
// filled because pop is held low.
module sync_length_deframer
	import sld_pkg::*;
#(
	parameter int SYNC_LENGTH  = SYNC_LENGTH_DEF,
	parameter int LENGTH_BYTES = LENGTH_BYTES_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] payload_byte,
	output logic       first_of_frame,
	output logic       last_of_frame
);

	logic      take;
	logic      emit;
	sld_item_t front_item;
	sld_item_t head_item;

	assign take = push && !full;

	sld_front #(
		.SYNC_LENGTH (SYNC_LENGTH),
		.LENGTH_BYTES(LENGTH_BYTES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.rx_byte(rx_byte),
		.emit   (emit),
		.item   (front_item)
	);

	sld_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (emit),
		.wr_item(front_item),
		.rd_en  (pop),
		.rd_item(head_item),
		.full   (full),
		.empty  (empty)
	);

	assign payload_byte   = head_item.payload_byte;
	assign first_of_frame = head_item.first_of_frame;
	assign last_of_frame  = head_item.last_of_frame;

endmodule

// ===== tb/sync_length_deframer_tb.sv =====
// Self-checking testbench for the sync/length deframer: directed, random, back-pressure.
module sync_length_deframer_tb;
	import sld_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SYNC_LEN   = SYNC_LENGTH_DEF;
	localparam int LEN_BYTES  = LENGTH_BYTES_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_ITEMS = 1200;

	typedef enum logic [1:0] {
		DF_HUNT = 2'd0,
		DF_LEN  = 2'd1,
		DF_DATA = 2'd2
	} df_phase_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] rx_byte = 8'h00;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] payload_byte;
	logic       first_of_frame;
	logic       last_of_frame;

	sync_length_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.payload_byte(payload_byte),
		.first_of_frame(first_of_frame),
		.last_of_frame(last_of_frame)
	);

	// deframer state mirror
	df_phase_t   df_phase;
	logic [3:0]  df_run;
	logic [3:0]  df_hdr;
	logic [63:0] df_len;
	logic [63:0] df_left;
	logic        df_first;
	sld_item_t   payload_q[$];

	int  errors = 0;
	int  sent_cnt = 0;
	bit  no_idle = 1'b0;
	bit  hold_req = 1'b0;
	int  hold_left = 0;
	int  pop_gap = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic df_hunt();
		df_phase = DF_HUNT;
		df_run = 4'd0;
		df_hdr = 4'd0;
		df_len = 64'd0;
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		sld_item_t it;
		case (df_phase)
			DF_LEN: begin
				df_len = {df_len[55:0], b};
				df_hdr = df_hdr + 4'd1;
				if (df_hdr >= LEN_BYTES) begin
					if (df_len == 64'd0) begin
						df_hunt();
					end else begin
						df_left = df_len;
						df_first = 1'b1;
						df_phase = DF_DATA;
						df_hdr = 4'd0;
					end
				end
			end
			DF_DATA: begin
				it.payload_byte = b;
				it.first_of_frame = df_first;
				it.last_of_frame = (df_left <= 64'd1);
				payload_q.push_back(it);
				df_first = 1'b0;
				if (df_left > 64'd0)
					df_left = df_left - 64'd1;
				if (df_left == 64'd0)
					df_hunt();
			end
			default: begin
				df_phase = DF_HUNT;
				if (b == SYNC_BYTE) begin
					if (df_run + 1 >= SYNC_LEN) begin
						df_run = 4'd0;
						df_hdr = 4'd0;
						df_len = 64'd0;
						df_phase = DF_LEN;
					end else begin
						df_run = df_run + 4'd1;
					end
				end else begin
					df_run = 4'd0;
				end
			end
		endcase
	endtask

	// call just after a rising edge; returns just after the accepting edge
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		deframe_byte(b);
		sent_cnt++;
	endtask

	task automatic send_sync();
		repeat (SYNC_LEN) send_byte(SYNC_BYTE);
	endtask

	task automatic send_length(input logic [63:0] n);
		for (int i = LEN_BYTES - 1; i >= 0; i--)
			send_byte(n[8*i +: 8]);
	endtask

	task automatic send_frame(input int len);
		send_sync();
		send_length(64'(len));
		repeat (len) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drain();
		while (payload_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_partial_sync();
		repeat (SYNC_LEN - 1) send_byte(SYNC_BYTE);
		send_byte(8'h00);
		send_frame(1);
	endtask

	task automatic test_zero_length_and_extremes();
		send_sync();
		send_length(64'd0);
		send_sync();
		send_length(64'd2);
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	task automatic test_back_pressure();
		hold_req = 1'b1;
		no_idle = 1'b1;
		send_frame(40);
		no_idle = 1'b0;
		push <= 1'b0;
		wait_drain();
	endtask

	task automatic test_random_stream();
		int stop_at;
		int kind;
		int r;
		stop_at = sent_cnt + RANDOM_ITEMS;
		while (sent_cnt < stop_at) begin
			no_idle = ($urandom_range(0, 5) == 0);
			repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 254)));
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				repeat ($urandom_range(1, SYNC_LEN - 1)) send_byte(SYNC_BYTE);
				send_byte(8'($urandom_range(0, 254)));
			end else if (kind == 1) begin
				send_sync();
				send_length(64'd0);
			end else begin
				r = $urandom_range(0, 19);
				if (r == 0)
					send_frame($urandom_range(256, 300));
				else if (r < 4)
					send_frame($urandom_range(17, 64));
				else
					send_frame($urandom_range(1, 16));
			end
		end
		no_idle = 1'b0;
	endtask

	// leaves the block inside an endless payload, so it runs last
	task automatic test_long_run_huge_length();
		repeat (SYNC_LEN + 1) send_byte(SYNC_BYTE);
		send_byte(8'h00);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'h0F);
		send_byte(8'hF0);
		send_byte(8'h01);
		send_byte(8'h80);
		repeat (30) send_byte(8'($urandom_range(0, 255)));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (pop_gap > 0) begin
			pop_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			pop_gap = pick_gap();
		end
	end

	always @(posedge clk) begin : check_out
		sld_item_t want;
		if (arst_n && pop && !empty) begin
			if (payload_q.size() == 0) begin
				errors++;
				$display("%0t: transfer out with nothing expected, payload_byte %h",
					$time, payload_byte);
			end else begin
				want = payload_q.pop_front();
				if (payload_byte !== want.payload_byte) begin
					errors++;
					$display("%0t: payload_byte expected %h actual %h",
						$time, want.payload_byte, payload_byte);
				end
				if (first_of_frame !== want.first_of_frame) begin
					errors++;
					$display("%0t: first_of_frame expected %b actual %b",
						$time, want.first_of_frame, first_of_frame);
				end
				if (last_of_frame !== want.last_of_frame) begin
					errors++;
					$display("%0t: last_of_frame expected %b actual %b",
						$time, want.last_of_frame, last_of_frame);
				end
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		wait (arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle = 0;
			else
				idle++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		df_hunt();
		df_left = 64'd0;
		df_first = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_partial_sync();
		test_zero_length_and_extremes();
		test_back_pressure();
		test_random_stream();
		test_long_run_huge_length();

		push <= 1'b0;
		wait_drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && payload_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sync_length_deframer.f =====
hdl/sld_pkg.sv
hdl/sld_front.sv
hdl/sld_queue.sv
hdl/sync_length_deframer.sv
tb/sync_length_deframer_tb.sv
